/* hw/rtl/camera_ray_generator_core_defines.svh */
// Assertion macros shared by the camera ray generator RTL.
`ifndef CAMERA_RAY_GENERATOR_CORE_DEFINES_SVH
`define CAMERA_RAY_GENERATOR_CORE_DEFINES_SVH

// Implication checked in the same cycle, off while reset is high.
`define CRG_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("camera ray generator check failed");

// Implication checked in the next cycle, active during reset too.
`define CRG_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("camera ray generator check failed");

`endif

/* hw/rtl/crg_pkg.sv */
// Shared types and constants of the camera ray generator.
package crg_pkg;

   // Field widths
   localparam int PIX_W      = 12;
   localparam int PLANE_FRAC = 20;
   localparam int PLANE_W    = 24;
   localparam int SRC_W      = 15;
   localparam int GRID_W     = 13;
   localparam int FOC_W      = 24;
   localparam int DIR_W      = 17;
   localparam int DIRZ_W     = 16;
   localparam int CSR_IDX_W  = 3;

   // Plane axis datapath
   localparam int A_W       = 28;
   localparam int NUM_W     = 38;
   localparam int DEN_W     = 37;
   localparam int REM_W     = 42;
   localparam int QUO_W     = 26;
   localparam int DIV_STEPS = 26;
   localparam int AXIS_LAT  = DIV_STEPS + 4;

   // Length and direction datapath
   localparam int SQ_W       = 48;
   localparam int ROOT_STEPS = 24;
   localparam int DIR_STEPS  = 17;
   localparam int DIR_REM_W  = 25;
   localparam int SIDE_LEN   = ROOT_STEPS + 1 + DIR_STEPS + 1;
   localparam int DIV_TAP    = ROOT_STEPS + 1;
   localparam int TOTAL_LAT  = AXIS_LAT + 2 + ROOT_STEPS + DIR_STEPS + 1;

   localparam logic [QUO_W-1:0] POS_LIMIT = QUO_W'(8388607);
   localparam logic [QUO_W-1:0] NEG_LIMIT = QUO_W'(8388608);
   localparam logic [4:0]       INT_LIMIT = 5'd16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FOCAL_X       = 3'd0,
      CSR_FOCAL_Y       = 3'd1,
      CSR_CENTER_X      = 3'd2,
      CSR_CENTER_Y      = 3'd3,
      CSR_GRID_WIDTH    = 3'd4,
      CSR_GRID_HEIGHT   = 3'd5,
      CSR_SOURCE_WIDTH  = 3'd6,
      CSR_SOURCE_HEIGHT = 3'd7
   } csr_index_type;

   // Result of one plane axis
   typedef struct packed {
      logic [PLANE_W-1:0] mag;
      logic               neg;
      logic               clip;
   } axis_out_type;

   // Per-ray data riding beside the length pipeline
   typedef struct packed {
      logic [PLANE_W-1:0] mag_x;
      logic [PLANE_W-1:0] mag_y;
      logic               neg_x;
      logic               neg_y;
      logic               clip;
   } ray_side_type;

endpackage

/* hw/rtl/crg_plane_axis.sv */
// One plane axis: pixel mapping, pipelined restoring divide, round and saturate.
module crg_plane_axis import crg_pkg::*; (
   input  logic               clock,
   input  logic [PIX_W-1:0]   pix,
   input  logic [SRC_W-1:0]   src,
   input  logic [GRID_W-1:0]  grid,
   input  logic [FOC_W-1:0]   ctr,
   input  logic [FOC_W-1:0]   foc,
   output axis_out_type       result
);

   logic [A_W-1:0]   a1_ff;
   logic [NUM_W-1:0] b1_ff;
   logic [DEN_W-1:0] den1_ff;
   logic [NUM_W-1:0] num2_ff;
   logic [DEN_W-1:0] den2_ff;
   logic             neg2_ff;

   logic [REM_W-1:0] rem_ff [DIV_STEPS+1];
   logic [REM_W-1:0] rem_in [DIV_STEPS+1];
   logic [QUO_W-1:0] q_ff   [DIV_STEPS+1];
   logic [QUO_W-1:0] q_in   [DIV_STEPS+1];
   logic [DEN_W-1:0] den_ff [DIV_STEPS+1];
   logic             neg_ff [DIV_STEPS+1];
   logic             sat_ff [DIV_STEPS+1];

   logic [FOC_W:0]   ctr_ofs;
   logic [NUM_W-1:0] a_full;
   logic [QUO_W-1:0] q_last;
   logic [QUO_W-1:0] rnd;
   logic [QUO_W-1:0] lim;
   logic             ovf;
   logic             clip;
   axis_out_type     result_in;
   axis_out_type     result_ff;

   // Stage 1: the three products
   assign ctr_ofs = {1'b0, ctr} + (FOC_W+1)'(128);

   always_ff @(posedge clock) begin
      a1_ff   <= A_W'({pix, 1'b1}) * A_W'(src);
      b1_ff   <= NUM_W'(ctr_ofs) * NUM_W'(grid);
      den1_ff <= DEN_W'(grid) * DEN_W'(foc);
   end

   // Stage 2: magnitude and sign of the numerator
   assign a_full = NUM_W'({a1_ff, 7'b0});

   always_ff @(posedge clock) begin
      num2_ff <= (a_full >= b1_ff) ? a_full - b1_ff : b1_ff - a_full;
      neg2_ff <= a_full < b1_ff;
      den2_ff <= den1_ff;
   end

   // Divide steps: stage 3 loads, then one quotient bit per stage
   // (a zero divisor with a zero numerator yields a zero quotient)
   always_comb begin
      logic             ge;
      logic [REM_W-1:0] dd;
      logic [REM_W-1:0] diff;
      rem_in[0] = REM_W'(num2_ff);
      q_in[0]   = '0;
      for (int k = 1; k <= DIV_STEPS; k++) begin
         dd        = {1'b0, den_ff[k-1], 4'b0};
         ge        = (den_ff[k-1] != '0) && (rem_ff[k-1] >= dd);
         diff      = ge ? rem_ff[k-1] - dd : rem_ff[k-1];
         rem_in[k] = {diff[REM_W-2:0], 1'b0};
         q_in[k]   = {q_ff[k-1][QUO_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= DIV_STEPS; k++) begin
         rem_ff[k] <= rem_in[k];
         q_ff[k]   <= q_in[k];
      end
      den_ff[0] <= den2_ff;
      neg_ff[0] <= neg2_ff;
      // quotient of 32 or more, or zero divisor with nonzero numerator
      sat_ff[0] <= (num2_ff != '0) && (REM_W'(num2_ff) >= {den2_ff, 5'b0});
      for (int k = 1; k <= DIV_STEPS; k++) begin
         den_ff[k] <= den_ff[k-1];
         neg_ff[k] <= neg_ff[k-1];
         sat_ff[k] <= sat_ff[k-1];
      end
   end

   // Final stage: round half away from zero, saturate
   assign q_last = q_ff[DIV_STEPS];
   assign rnd    = {1'b0, q_last[QUO_W-1:1]} + QUO_W'(q_last[0]);
   assign lim    = neg_ff[DIV_STEPS] ? NEG_LIMIT : POS_LIMIT;
   assign ovf    = sat_ff[DIV_STEPS] || (q_last[QUO_W-1:PLANE_FRAC+1] > INT_LIMIT);
   assign clip   = ovf || (rnd > lim);

   always_comb begin
      result_in.clip = clip;
      result_in.mag  = clip ? lim[PLANE_W-1:0] : rnd[PLANE_W-1:0];
      result_in.neg  = neg_ff[DIV_STEPS] && (clip || (rnd != '0));
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

/* hw/rtl/crg_dir_div.sv */
// Pipelined restoring divide for one direction component, rounded to nearest.
module crg_dir_div import crg_pkg::*; (
   input  logic               clock,
   input  logic [PLANE_W-1:0] num,
   input  logic [PLANE_W-1:0] den,
   output logic [DIR_W-1:0]   quo
);

   logic [DIR_REM_W-1:0] rem_ff [DIR_STEPS];
   logic [DIR_REM_W-1:0] rem_in [DIR_STEPS];
   logic [DIR_W-1:0]     q_ff   [DIR_STEPS];
   logic [DIR_W-1:0]     q_in   [DIR_STEPS];
   logic [PLANE_W-1:0]   den_ff [DIR_STEPS];
   logic [DIR_W-1:0]     q_last;

   // One quotient bit per stage, most significant first
   always_comb begin
      logic [DIR_REM_W-1:0] r;
      logic [DIR_W-1:0]     q;
      logic [PLANE_W-1:0]   d;
      logic                 ge;
      logic [DIR_REM_W-1:0] diff;
      for (int k = 0; k < DIR_STEPS; k++) begin
         if (k == 0) begin
            r = {1'b0, num};
            q = '0;
            d = den;
         end else begin
            r = rem_ff[k-1];
            q = q_ff[k-1];
            d = den_ff[k-1];
         end
         ge        = r >= {1'b0, d};
         diff      = ge ? r - {1'b0, d} : r;
         rem_in[k] = {diff[DIR_REM_W-2:0], 1'b0};
         q_in[k]   = {q[DIR_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DIR_STEPS; k++) begin
         rem_ff[k] <= rem_in[k];
         q_ff[k]   <= q_in[k];
      end
      den_ff[0] <= den;
      for (int k = 1; k < DIR_STEPS; k++) begin
         den_ff[k] <= den_ff[k-1];
      end
   end

   // Drop the extra bit with rounding
   assign q_last = q_ff[DIR_STEPS-1];
   assign quo    = {1'b0, q_last[DIR_W-1:1]} + DIR_W'(q_last[0]);

endmodule

/* hw/rtl/camera_ray_generator_core.sv */
// Camera ray generator top level: registers, plane axes, length and direction pipeline.
//
// Usage: a pixel transaction (req_pixel_col, req_pixel_row) is taken at each rising
// edge with start high and busy low. busy is always low, so one pixel can be
// issued every cycle. Each pixel gives one result: rsp_valid is high for one
// cycle with plane_x/y, dir_x/y/z and clipped on the rsp_ ports. The pipeline
// holds the 26-step plane divider, the 24-step square root of the squared
// length and the 17-step direction divider, each one step per stage;
// throughput is one result per cycle. The receiver cannot stall; results
// leave in issue order.
// Camera setup is written through csr_we/csr_index/csr_wdata, one register per cycle;
// the user must write it only while no pixel is in flight; the block does not enforce it.
// Synchronous reset clears the pipeline valid bits and loads the default setup
// (focal 1.0, centers 0, sizes 1); no clearing pass is needed.
`include "camera_ray_generator_core_defines.svh"
module camera_ray_generator_core import crg_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [PIX_W-1:0]          req_pixel_col,
   input  logic [PIX_W-1:0]          req_pixel_row,
   output logic                      rsp_valid,
   output logic signed [PLANE_W-1:0] rsp_plane_x,
   output logic signed [PLANE_W-1:0] rsp_plane_y,
   output logic signed [DIR_W-1:0]   rsp_dir_x,
   output logic signed [DIR_W-1:0]   rsp_dir_y,
   output logic [DIRZ_W-1:0]         rsp_dir_z,
   output logic                      rsp_clipped,
   input  logic                      csr_we,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [FOC_W-1:0]          csr_wdata
);

   logic [FOC_W-1:0]  focal_x_ff, focal_y_ff, center_x_ff, center_y_ff;
   logic [GRID_W-1:0] grid_width_ff, grid_height_ff;
   logic [SRC_W-1:0]  source_width_ff, source_height_ff;

   logic              valid_ff [TOTAL_LAT];
   axis_out_type      axis_x, axis_y;
   logic [SQ_W-1:0]   sqx_ff, sqy_ff, s_ff;
   ray_side_type      side_ff [SIDE_LEN];
   ray_side_type      side_in;
   logic [SQ_W-1:0]   v_ff [ROOT_STEPS];
   logic [SQ_W-1:0]   v_in [ROOT_STEPS];
   logic [SQ_W-1:0]   r_ff [ROOT_STEPS];
   logic [SQ_W-1:0]   r_in [ROOT_STEPS];
   logic [PLANE_W-1:0] len;
   logic [DIR_W-1:0]  quo_x, quo_y, quo_z;
   ray_side_type      side_out;

   assign busy = 1'b0;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff       <= FOC_W'(256);
         focal_y_ff       <= FOC_W'(256);
         center_x_ff      <= '0;
         center_y_ff      <= '0;
         grid_width_ff    <= GRID_W'(1);
         grid_height_ff   <= GRID_W'(1);
         source_width_ff  <= SRC_W'(1);
         source_height_ff <= SRC_W'(1);
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_FOCAL_X:       focal_x_ff       <= csr_wdata;
            CSR_FOCAL_Y:       focal_y_ff       <= csr_wdata;
            CSR_CENTER_X:      center_x_ff      <= csr_wdata;
            CSR_CENTER_Y:      center_y_ff      <= csr_wdata;
            CSR_GRID_WIDTH:    grid_width_ff    <= csr_wdata[GRID_W-1:0];
            CSR_GRID_HEIGHT:   grid_height_ff   <= csr_wdata[GRID_W-1:0];
            CSR_SOURCE_WIDTH:  source_width_ff  <= csr_wdata[SRC_W-1:0];
            CSR_SOURCE_HEIGHT: source_height_ff <= csr_wdata[SRC_W-1:0];
            default:           focal_x_ff       <= focal_x_ff;
         endcase
      end
   end

   // Valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < TOTAL_LAT; k++) valid_ff[k] <= 1'b0;
      end else begin
         valid_ff[0] <= start && !busy;
         for (int k = 1; k < TOTAL_LAT; k++) valid_ff[k] <= valid_ff[k-1];
      end
   end

   // Plane axes
   crg_plane_axis u_axis_x (
      .clock  (clock),
      .pix    (req_pixel_col),
      .src    (source_width_ff),
      .grid   (grid_width_ff),
      .ctr    (center_x_ff),
      .foc    (focal_x_ff),
      .result (axis_x)
   );

   crg_plane_axis u_axis_y (
      .clock  (clock),
      .pix    (req_pixel_row),
      .src    (source_height_ff),
      .grid   (grid_height_ff),
      .ctr    (center_y_ff),
      .foc    (focal_y_ff),
      .result (axis_y)
   );

   // Squares, then the squared length with the unit z term
   always_ff @(posedge clock) begin
      sqx_ff <= SQ_W'(axis_x.mag) * SQ_W'(axis_x.mag);
      sqy_ff <= SQ_W'(axis_y.mag) * SQ_W'(axis_y.mag);
      s_ff   <= sqx_ff + sqy_ff + (SQ_W'(1) << (2 * PLANE_FRAC));
   end

   // Side data shift line
   always_comb begin
      side_in.mag_x = axis_x.mag;
      side_in.mag_y = axis_y.mag;
      side_in.neg_x = axis_x.neg;
      side_in.neg_y = axis_y.neg;
      side_in.clip  = axis_x.clip || axis_y.clip;
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= side_in;
      for (int k = 1; k < SIDE_LEN; k++) side_ff[k] <= side_ff[k-1];
   end

   // Integer square root, one result bit per stage
   always_comb begin
      logic [SQ_W-1:0] v;
      logic [SQ_W-1:0] r;
      logic [SQ_W-1:0] bitv;
      logic [SQ_W:0]   t;
      for (int k = 0; k < ROOT_STEPS; k++) begin
         if (k == 0) begin
            v = s_ff;
            r = '0;
         end else begin
            v = v_ff[k-1];
            r = r_ff[k-1];
         end
         bitv = SQ_W'(1) << (SQ_W - 2 - 2 * k);
         t    = {1'b0, r} + {1'b0, bitv};
         if ({1'b0, v} >= t) begin
            v_in[k] = v - t[SQ_W-1:0];
            r_in[k] = (r >> 1) + bitv;
         end else begin
            v_in[k] = v;
            r_in[k] = r >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < ROOT_STEPS; k++) begin
         v_ff[k] <= v_in[k];
         r_ff[k] <= r_in[k];
      end
   end

   assign len = r_ff[ROOT_STEPS-1][PLANE_W-1:0];

   // Direction components
   crg_dir_div u_dir_x (
      .clock (clock),
      .num   (side_ff[DIV_TAP].mag_x),
      .den   (len),
      .quo   (quo_x)
   );

   crg_dir_div u_dir_y (
      .clock (clock),
      .num   (side_ff[DIV_TAP].mag_y),
      .den   (len),
      .quo   (quo_y)
   );

   crg_dir_div u_dir_z (
      .clock (clock),
      .num   (PLANE_W'(1) << PLANE_FRAC),
      .den   (len),
      .quo   (quo_z)
   );

   // Output register
   assign side_out = side_ff[SIDE_LEN-1];

   always_ff @(posedge clock) begin
      rsp_plane_x <= side_out.neg_x ? -side_out.mag_x : side_out.mag_x;
      rsp_plane_y <= side_out.neg_y ? -side_out.mag_y : side_out.mag_y;
      rsp_dir_x   <= side_out.neg_x ? -quo_x : quo_x;
      rsp_dir_y   <= side_out.neg_y ? -quo_y : quo_y;
      rsp_dir_z   <= quo_z[DIRZ_W-1:0];
      rsp_clipped <= side_out.clip;
   end

   assign rsp_valid = valid_ff[TOTAL_LAT-1];

   // Checks
   `CRG_ASSERT_NEXT(a_reset_clears, clock, reset, !rsp_valid)
   `CRG_ASSERT_IMPL(a_dir_z_range, clock, reset, rsp_valid, (rsp_dir_z != '0) && (rsp_dir_z <= 16'd32768))
   `CRG_ASSERT_IMPL(a_zero_plane_x, clock, reset, rsp_valid && (rsp_plane_x == '0), rsp_dir_x == '0)
   `CRG_ASSERT_IMPL(a_sign_x, clock, reset, rsp_valid && rsp_plane_x[PLANE_W-1], rsp_dir_x[DIR_W-1] || (rsp_dir_x == '0))

endmodule

/* dv/tb_camera_ray_generator_core.sv */
// Self-checking testbench for camera_ray_generator_core: random and directed pixels
// are driven through the command port and each ray is checked against a local predictor.
module tb_camera_ray_generator_core import crg_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FLUSH_CYCLES = TOTAL_LAT + 30;

   // One entry of the stimulus list: a register write or a pixel
   typedef struct {
      bit                 is_cfg;
      csr_index_type      idx;
      logic [FOC_W-1:0]   data;
      logic [PIX_W-1:0]   col;
      logic [PIX_W-1:0]   row;
      int                 idle_pct;
   } stim_item_type;

   typedef struct packed {
      logic [PLANE_W-1:0] plane_x;
      logic [PLANE_W-1:0] plane_y;
      logic [DIR_W-1:0]   dir_x;
      logic [DIR_W-1:0]   dir_y;
      logic [DIRZ_W-1:0]  dir_z;
      logic               clipped;
   } ray_type;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic [PIX_W-1:0]          req_pixel_col;
   logic [PIX_W-1:0]          req_pixel_row;
   logic                      rsp_valid;
   logic signed [PLANE_W-1:0] rsp_plane_x;
   logic signed [PLANE_W-1:0] rsp_plane_y;
   logic signed [DIR_W-1:0]   rsp_dir_x;
   logic signed [DIR_W-1:0]   rsp_dir_y;
   logic [DIRZ_W-1:0]         rsp_dir_z;
   logic                      rsp_clipped;
   logic                      csr_we;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [FOC_W-1:0]          csr_wdata;

   stim_item_type    pending_q[$];
   ray_type          ray_q[$];
   logic [63:0]      cam_reg[8];
   int               fail_count = 0;

   camera_ray_generator_core DUT (.*);

   // Clock and reset
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   initial begin
      reset = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   // Register masks by index
   function automatic logic [63:0] reg_mask(input int i);
      case (i)
         CSR_GRID_WIDTH, CSR_GRID_HEIGHT:     reg_mask = 64'h1FFF;
         CSR_SOURCE_WIDTH, CSR_SOURCE_HEIGHT: reg_mask = 64'h7FFF;
         default:                             reg_mask = 64'hFF_FFFF;
      endcase
   endfunction

   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // One image-plane coordinate as magnitude and sign, rounded and saturated
   function automatic void plane_coord(input logic [63:0] pix, src, grid, ctr, foc,
                                       output logic [63:0] mag, output bit neg,
                                       inout bit clip);
      logic [63:0] a, b, num, den, lim, ip, rem, q, r;
      a = (2 * pix + 1) * src * 128;
      b = (ctr + 128) * grid;
      num = (a >= b) ? a - b : b - a;
      den = grid * foc;
      neg = (a < b);
      lim = neg ? 64'd8388608 : 64'd8388607;
      if (num == 0) begin
         mag = 0;
         neg = 0;
         return;
      end
      if (den == 0) begin
         mag = lim;
         clip = 1;
         return;
      end
      ip = num / den;
      rem = num % den;
      if (ip > ((64'd1 << 24) >> PLANE_FRAC)) begin
         mag = lim;
         clip = 1;
         return;
      end
      q = ip;
      for (int i = 0; i <= PLANE_FRAC; i++) begin
         rem = rem << 1;
         q = q << 1;
         if (rem >= den) begin
            rem = rem - den;
            q = q | 1;
         end
      end
      r = (q + 1) >> 1;
      if (r > lim) begin
         r = lim;
         clip = 1;
      end
      mag = r;
      if (r == 0) neg = 0;
   endfunction

   // Direction component: round(|c| * 2^15 / len) with the sign of c
   function automatic logic [DIR_W-1:0] unit_comp(input logic [63:0] mag, input bit neg,
                                                  input logic [63:0] len);
      logic [63:0] d;
      d = (((mag << 16) / len) + 1) >> 1;
      return neg ? DIR_W'(-d) : DIR_W'(d);
   endfunction

   function automatic ray_type predict_ray(input logic [PIX_W-1:0] col, row);
      ray_type     res;
      logic [63:0] mx, my, len;
      bit          nx, ny, clip;
      logic [DIR_W-1:0] dz;
      clip = 0;
      plane_coord(col, cam_reg[CSR_SOURCE_WIDTH], cam_reg[CSR_GRID_WIDTH],
                  cam_reg[CSR_CENTER_X], cam_reg[CSR_FOCAL_X], mx, nx, clip);
      plane_coord(row, cam_reg[CSR_SOURCE_HEIGHT], cam_reg[CSR_GRID_HEIGHT],
                  cam_reg[CSR_CENTER_Y], cam_reg[CSR_FOCAL_Y], my, ny, clip);
      len = int_sqrt(mx * mx + my * my + (64'd1 << (2 * PLANE_FRAC)));
      res.plane_x = nx ? PLANE_W'(-mx) : PLANE_W'(mx);
      res.plane_y = ny ? PLANE_W'(-my) : PLANE_W'(my);
      res.dir_x   = unit_comp(mx, nx, len);
      res.dir_y   = unit_comp(my, ny, len);
      dz          = unit_comp(64'd1 << PLANE_FRAC, 0, len);
      res.dir_z   = dz[DIRZ_W-1:0];
      res.clipped = clip;
      return res;
   endfunction

   // Driver: register writes only with nothing in flight, pixels with random gaps
   always @(posedge clock) begin
      bit               nxt_start;
      bit               nxt_we;
      stim_item_type    it;
      if (reset) begin
         start         <= 1'b0;
         csr_we        <= 1'b0;
         csr_index     <= '0;
         csr_wdata     <= '0;
         req_pixel_col <= '0;
         req_pixel_row <= '0;
         for (int i = 0; i < 8; i++) cam_reg[i] = 0;
         cam_reg[CSR_FOCAL_X] = 256;
         cam_reg[CSR_FOCAL_Y] = 256;
         cam_reg[CSR_GRID_WIDTH] = 1;
         cam_reg[CSR_GRID_HEIGHT] = 1;
         cam_reg[CSR_SOURCE_WIDTH] = 1;
         cam_reg[CSR_SOURCE_HEIGHT] = 1;
      end else begin
         nxt_start = start;
         nxt_we = 1'b0;
         if (start && !busy) begin
            ray_q.push_back(predict_ray(req_pixel_col, req_pixel_row));
            nxt_start = 1'b0;
         end
         if (!nxt_start && !csr_we && pending_q.size() > 0) begin
            it = pending_q[0];
            if (it.is_cfg) begin
               if (!start && ray_q.size() == 0) begin
                  nxt_we = 1'b1;
                  csr_index <= it.idx;
                  csr_wdata <= it.data;
                  cam_reg[it.idx] = it.data & reg_mask(it.idx);
                  void'(pending_q.pop_front());
               end
            end else if ($urandom_range(99) >= it.idle_pct) begin
               nxt_start = 1'b1;
               req_pixel_col <= it.col;
               req_pixel_row <= it.row;
               void'(pending_q.pop_front());
            end
         end
         start  <= nxt_start;
         csr_we <= nxt_we;
      end
   end

   // Monitor: each strobed ray against the oldest prediction
   always @(posedge clock) begin
      ray_type want;
      if (!reset && rsp_valid) begin
         if (ray_q.size() == 0) begin
            $error("unexpected ray transaction");
            fail_count++;
         end else begin
            want = ray_q.pop_front();
            if (rsp_plane_x !== want.plane_x) begin
               $error("plane_x exp %0h got %0h", want.plane_x, rsp_plane_x);
               fail_count++;
            end
            if (rsp_plane_y !== want.plane_y) begin
               $error("plane_y exp %0h got %0h", want.plane_y, rsp_plane_y);
               fail_count++;
            end
            if (rsp_dir_x !== want.dir_x) begin
               $error("dir_x exp %0h got %0h", want.dir_x, rsp_dir_x);
               fail_count++;
            end
            if (rsp_dir_y !== want.dir_y) begin
               $error("dir_y exp %0h got %0h", want.dir_y, rsp_dir_y);
               fail_count++;
            end
            if (rsp_dir_z !== want.dir_z) begin
               $error("dir_z exp %0h got %0h", want.dir_z, rsp_dir_z);
               fail_count++;
            end
            if (rsp_clipped !== want.clipped) begin
               $error("clipped exp %0b got %0b", want.clipped, rsp_clipped);
               fail_count++;
            end
         end
      end
   end

   task automatic add_cfg(input csr_index_type idx, input logic [63:0] val);
      stim_item_type it;
      it.is_cfg   = 1'b1;
      it.idx      = idx;
      it.data     = val[FOC_W-1:0];
      it.col      = '0;
      it.row      = '0;
      it.idle_pct = 0;
      pending_q.push_back(it);
   endtask

   task automatic add_pixel(input int col, row, idle);
      stim_item_type it;
      it.is_cfg   = 1'b0;
      it.idx      = CSR_FOCAL_X;
      it.data     = '0;
      it.col      = PIX_W'(col);
      it.row      = PIX_W'(row);
      it.idle_pct = idle;
      pending_q.push_back(it);
   endtask

   task automatic add_camera(input logic [63:0] fx, fy, cx, cy, gw, gh, sw, sh);
      add_cfg(CSR_FOCAL_X, fx);
      add_cfg(CSR_FOCAL_Y, fy);
      add_cfg(CSR_CENTER_X, cx);
      add_cfg(CSR_CENTER_Y, cy);
      add_cfg(CSR_GRID_WIDTH, gw);
      add_cfg(CSR_GRID_HEIGHT, gh);
      add_cfg(CSR_SOURCE_WIDTH, sw);
      add_cfg(CSR_SOURCE_HEIGHT, sh);
   endtask

   // Stimulus list
   initial begin
      logic [63:0] rv[8];
      int          idle;
      int          k;
      // reset setup: unit focal, pixels map to their index, large ones saturate
      add_pixel(0, 0, 0);
      add_pixel(4095, 4095, 0);
      add_pixel(3, 12'hA5A, 0);
      // typical camera, corners and grid middle
      add_camera(500 * 256, 480 * 256, 320 * 256, 240 * 256, 640, 480, 1280, 960);
      add_pixel(0, 0, 0);
      add_pixel(639, 479, 0);
      add_pixel(319, 239, 0);
      add_pixel(639, 0, 0);
      add_pixel(4095, 4095, 0);
      // every register at its top value
      add_camera(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 8191, 8191, 32767, 32767);
      add_pixel(0, 0, 0);
      add_pixel(4095, 4095, 0);
      add_pixel(2048, 1024, 0);
      // zero divisors and zero source size
      add_camera(0, 256, 0, 0, 1, 0, 1, 0);
      add_pixel(0, 0, 0);
      add_pixel(5, 7, 0);
      add_camera(256, 0, 24'h000080, 0, 0, 5, 0, 1);
      add_pixel(0, 0, 0);
      add_pixel(4095, 2, 0);
      // smallest focal length, saturation on both signs
      add_camera(1, 1, 24'h7FFF00, 0, 16, 16, 64, 64);
      add_pixel(0, 15, 0);
      add_pixel(15, 0, 0);
      add_pixel(8, 8, 0);

      // random cameras, then pixels mostly inside the grid
      for (int ph = 0; ph < 13; ph++) begin
         idle = (ph < 4) ? 36 : (ph < 8) ? 46 : 0;
         rv[CSR_SOURCE_WIDTH]  = $urandom_range(1, 16384);
         rv[CSR_SOURCE_HEIGHT] = $urandom_range(1, 16384);
         rv[CSR_GRID_WIDTH]    = $urandom_range(1, 4096);
         rv[CSR_GRID_HEIGHT]   = $urandom_range(1, 4096);
         rv[CSR_FOCAL_X]  = $urandom_range(64, rv[CSR_SOURCE_WIDTH] * 256) & 24'hFFFFFF;
         rv[CSR_FOCAL_Y]  = $urandom_range(64, rv[CSR_SOURCE_HEIGHT] * 256) & 24'hFFFFFF;
         rv[CSR_CENTER_X] = $urandom_range(0, rv[CSR_SOURCE_WIDTH] * 256);
         rv[CSR_CENTER_Y] = $urandom_range(0, rv[CSR_SOURCE_HEIGHT] * 256);
         // now and then one register at a raw extreme or full random bits
         if ($urandom_range(2) == 0) begin
            k = $urandom_range(7);
            case ($urandom_range(2))
               0:       rv[k] = 0;
               1:       rv[k] = reg_mask(k);
               default: rv[k] = $urandom() & reg_mask(k);
            endcase
         end
         add_camera(rv[0], rv[1], rv[2], rv[3], rv[4], rv[5], rv[6], rv[7]);
         for (int n = 0; n < 50; n++) begin
            if ($urandom_range(9) == 0)
               add_pixel($urandom(), $urandom(), idle);
            else
               add_pixel($urandom_range(0, (rv[CSR_GRID_WIDTH] - 1) & 12'hFFF),
                         $urandom_range(0, (rv[CSR_GRID_HEIGHT] - 1) & 12'hFFF), idle);
         end
      end

      // drain, then let the pipeline settle
      @(posedge clock);
      while (pending_q.size() > 0 || start || ray_q.size() > 0) @(posedge clock);
      repeat (FLUSH_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("tb_camera_ray_generator_core OK");
      else
         $display("tb_camera_ray_generator_core NOT OK");
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("tb_camera_ray_generator_core NOT OK");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/crg_pkg.sv
hw/rtl/crg_plane_axis.sv
hw/rtl/crg_dir_div.sv
hw/rtl/camera_ray_generator_core.sv
dv/tb_camera_ray_generator_core.sv
